### hdl/stpg_pkg.sv
// ----------------------------------------------------------------------------
// stpg_pkg
// Types and codes shared by the stepper ramp pulse generator.
// ----------------------------------------------------------------------------
`default_nettype none

package stpg_pkg;

  // command codes
  localparam logic [2:0] KIND_EVENT = 3'd0;
  localparam logic [2:0] KIND_POS   = 3'd1;
  localparam logic [2:0] KIND_VEL   = 3'd2;
  localparam logic [2:0] KIND_DECEL = 3'd3;
  localparam logic [2:0] KIND_HOME  = 3'd4;
  localparam logic [2:0] KIND_HALT  = 3'd5;

  // configuration register indexes
  localparam logic [2:0] CFG_HALF_CLOCK = 3'd0;
  localparam logic [2:0] CFG_SPR        = 3'd1;
  localparam logic [2:0] CFG_AXIS       = 3'd2;
  localparam logic [2:0] CFG_HOME_PER   = 3'd3;
  localparam logic [2:0] CFG_SWITCHES   = 3'd4;

  localparam int DIV_W = 36;

  typedef enum logic [1:0] {
    M_STOP = 2'd0,
    M_HOME = 2'd1,
    M_POS  = 2'd2,
    M_VEL  = 2'd3
  } mode_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_LIMIT,
    S_PLAN,
    S_DIV,
    S_APPLY,
    S_HOLD
  } fsm_state_t;

  typedef enum logic [2:0] {
    OP_NONE,
    OP_FIRST,
    OP_ACCEL,
    OP_CRUISE,
    OP_DECEL
  } ramp_op_t;

  typedef struct packed {
    logic [2:0]  kind;
    logic [23:0] steps;
    logic [23:0] accel_len;
    logic [23:0] decel_len;
    logic [22:0] freq;
    logic [31:0] first_period;
    logic        dir;
    logic        home_switch;
    logic        far_switch;
  } cmd_t;

  typedef struct packed {
    logic               pulse_level;
    logic               dir_level;
    logic [31:0]        period;
    logic               period_load;
    logic               timer_on;
    logic               moving;
    logic               homed;
    logic [1:0]         mode;
    logic signed [31:0] step_position;
  } res_t;

endpackage

`default_nettype wire

### hdl/stepper_trapezoid_pulse_generator_core.sv
// ----------------------------------------------------------------------------
// stepper_trapezoid_pulse_generator_core
// Stepper step/direction generator with a linear-speed integer ramp.
// ----------------------------------------------------------------------------
// Each transaction on the cmd channel is either a timer compare event or a
// motion command, and yields exactly one res transaction carrying the step
// and direction levels, the timer period in effect (with a load flag), and
// motion status. An item that needs no division passes the limit, plan,
// apply and hold states before its result is registered on res; an item
// with a division also waits in the divide state for the single serial
// divider, which resolves one quotient bit per cycle over a 36-bit signed
// dividend, until its done flag is seen.
// Items are processed one at a time, but the next one is taken while a
// finished result still waits in the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module stepper_trapezoid_pulse_generator_core #(
  parameter int DEBOUNCE_COUNT = 10,
  parameter int COUNT_WIDTH    = 32
) (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           cmd_valid,
  output logic                cmd_ready,
  input  wire stpg_pkg::cmd_t cmd,
  output logic                res_valid,
  input  wire logic           res_ready,
  output stpg_pkg::res_t      res,
  input  wire logic           cfg_valid,
  output logic                cfg_ready,
  input  wire logic [2:0]     cfg_index,
  input  wire logic [31:0]    cfg_data
);
  import stpg_pkg::*;

  // saturation bound of the step counters
  localparam logic [31:0] CMAX = 32'((33'd1 << COUNT_WIDTH) - 33'd1);
  localparam int DB_W = $clog2(DEBOUNCE_COUNT + 1);
  localparam logic [DB_W-1:0] DB_LIM = DB_W'(DEBOUNCE_COUNT);

  typedef struct packed {
    logic        pulse;
    logic [31:0] sc;
    logic [31:0] pos;
  } tog_t;

  function automatic logic [31:0] csat(input logic [32:0] v);
    return (v > {1'b0, CMAX}) ? CMAX : v[31:0];
  endfunction

  // one step-pin toggle; the rising edge counts a step
  function automatic tog_t toggle_f(input tog_t t, input logic dir);
    tog_t o;
    o = t;
    if (t.pulse) begin
      o.pulse = 1'b0;
    end else begin
      o.pulse = 1'b1;
      if (t.sc < CMAX) o.sc = t.sc + 32'd1;
      o.pos = dir ? t.pos + 32'd1 : t.pos - 32'd1;
    end
    return o;
  endfunction

  // --------------------------------------------------------------------------
  // configuration registers, always writable
  // --------------------------------------------------------------------------
  logic [25:0] timer_half_clock;
  logic [15:0] steps_per_rev;
  logic [30:0] axis_steps;
  logic [31:0] homing_period;
  logic        switches_present;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      timer_half_clock <= 26'd5250000;
      steps_per_rev    <= 16'd200;
      axis_steps       <= '0;
      homing_period    <= 32'd52500;
      switches_present <= 1'b0;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CFG_HALF_CLOCK: timer_half_clock <= cfg_data[25:0];
        CFG_SPR:        steps_per_rev    <= cfg_data[15:0];
        CFG_AXIS:       axis_steps       <= cfg_data[30:0];
        CFG_HOME_PER:   homing_period    <= cfg_data;
        CFG_SWITCHES:   switches_present <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // motion state
  // --------------------------------------------------------------------------
  mode_t              mode;
  logic               pulse;
  logic               direction;
  logic [31:0]        step_count;
  logic [31:0]        total_steps;
  logic [31:0]        accel_end;
  logic [31:0]        decel_start;
  logic [22:0]        target_freq;
  logic [31:0]        start_period;
  logic [31:0]        prev_period;
  logic signed [DIV_W-1:0] remainder;
  logic [31:0]        position;
  logic [31:0]        min_limit;
  logic [31:0]        max_limit;
  logic               homed, phase1, far_side, stop_req, moving, timer_on, loaded;
  logic [31:0]        cur_period;
  logic [DB_W-1:0]    home_db, far_db;

  mode_t              mode_next;
  logic               pulse_next, direction_next;
  logic [31:0]        step_count_next, total_steps_next, accel_end_next, decel_start_next;
  logic [22:0]        target_freq_next;
  logic [31:0]        start_period_next, prev_period_next;
  logic signed [DIV_W-1:0] remainder_next;
  logic [31:0]        position_next, min_limit_next, max_limit_next;
  logic               homed_next, phase1_next, far_side_next, stop_req_next;
  logic               moving_next, timer_on_next, loaded_next;
  logic [31:0]        cur_period_next;
  logic [DB_W-1:0]    home_db_next, far_db_next;

  fsm_state_t state, state_next;
  cmd_t       cmd_q;

  // --------------------------------------------------------------------------
  // shared divider
  // --------------------------------------------------------------------------
  logic                    div_start, div_busy, div_done, div_need;
  logic signed [DIV_W-1:0] div_num, div_den, div_q, div_r;

  stpg_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (div_num),
    .den   (div_den),
    .busy  (div_busy),
    .done  (div_done),
    .quot  (div_q),
    .rem   (div_r)
  );

  // --------------------------------------------------------------------------
  // command decode shared by planning and update
  // --------------------------------------------------------------------------
  logic [23:0] acc_c, dec_c;
  logic [24:0] acc_sum;
  logic [22:0] cmd_freq1;
  logic [22:0] tgt_freq1;
  ramp_op_t    op;
  logic [32:0] dec_dist;
  logic signed [DIV_W-1:0] ramp_num;

  always_comb begin
    acc_c   = (cmd_q.accel_len > cmd_q.steps) ? cmd_q.steps : cmd_q.accel_len;
    dec_c   = (cmd_q.decel_len > cmd_q.steps) ? cmd_q.steps : cmd_q.decel_len;
    acc_sum = {1'b0, acc_c} + {1'b0, dec_c};
    if (acc_sum > {1'b0, cmd_q.steps}) begin
      acc_c = cmd_q.steps >> 1;
      dec_c = cmd_q.steps >> 1;
    end
  end

  assign cmd_freq1 = (cmd_q.freq == '0) ? 23'd1 : cmd_q.freq;
  assign tgt_freq1 = (target_freq == '0) ? 23'd1 : target_freq;
  assign dec_dist  = {1'b0, step_count} - {1'b0, total_steps};
  assign ramp_num  = $signed({3'b000, prev_period, 1'b0}) + remainder;

  // which ramp step a timer event takes in the current state
  always_comb begin
    op = OP_NONE;
    if (mode == M_POS) begin
      if (step_count < total_steps && !pulse) begin
        if (step_count == '0) op = OP_FIRST;
        else if (step_count < accel_end) op = OP_ACCEL;
        else if (step_count < decel_start &&
                 {1'b0, decel_start} != {1'b0, accel_end} + 33'd1) op = OP_CRUISE;
        else op = OP_DECEL;
      end
    end else if (mode == M_VEL) begin
      if (stop_req) begin
        if (step_count < total_steps && !pulse) op = OP_DECEL;
      end else if (!pulse) begin
        if (step_count == '0) op = OP_FIRST;
        else if (step_count < accel_end) op = OP_ACCEL;
        else if (step_count == accel_end) op = OP_CRUISE;
      end
    end
  end

  // divider operands: ramp recurrence or clock / frequency
  always_comb begin
    div_need = 1'b0;
    div_num  = $signed({10'd0, timer_half_clock});
    div_den  = $signed({13'd0, cmd_freq1});
    unique case (cmd_q.kind)
      KIND_EVENT: begin
        priority case (op)
          OP_ACCEL: begin
            div_need = 1'b1;
            div_num  = ramp_num;
            div_den  = $signed({2'b00, step_count, 2'b01});
          end
          OP_DECEL: begin
            div_need = 1'b1;
            div_num  = ramp_num;
            div_den  = $signed({dec_dist[32], dec_dist, 2'b01});
          end
          OP_CRUISE: begin
            div_need = 1'b1;
            div_den  = $signed({13'd0, tgt_freq1});
          end
          default: ;
        endcase
      end
      KIND_POS:  div_need = (acc_c == '0);
      KIND_VEL:  div_need = (cmd_q.accel_len == '0);
      KIND_HOME: div_need = switches_present;
      default: ;
    endcase
  end

  assign div_start = (state == S_PLAN) && div_need;

  // --------------------------------------------------------------------------
  // soft limit check, done before planning so a limit stop shapes the ramp
  // --------------------------------------------------------------------------
  logic [31:0] spr_prod;
  logic [13:0] spr_fifth;
  logic        limit_hit;

  assign spr_prod  = 32'(steps_per_rev) * 32'd52429;   // x/5 exact for 16 bits
  assign spr_fifth = spr_prod[31:18];
  assign limit_hit = (cmd_q.kind == KIND_EVENT) && homed && !stop_req &&
                     ((direction && $signed(position) > $signed(max_limit)) ||
                      (!direction && $signed(position) < $signed(min_limit)));

  // --------------------------------------------------------------------------
  // per-item update
  // --------------------------------------------------------------------------
  always_comb begin
    logic hp, fp, hf, ff, fire;
    logic [31:0] p;
    tog_t tg;

    hp   = !cmd_q.home_switch;
    fp   = !cmd_q.far_switch;
    hf   = 1'b0;
    ff   = 1'b0;
    fire = 1'b0;
    p    = prev_period - div_q[31:0];
    tg   = '0;

    mode_next         = mode;
    pulse_next        = pulse;
    direction_next    = direction;
    step_count_next   = step_count;
    total_steps_next  = total_steps;
    accel_end_next    = accel_end;
    decel_start_next  = decel_start;
    target_freq_next  = target_freq;
    start_period_next = start_period;
    prev_period_next  = prev_period;
    remainder_next    = remainder;
    position_next     = position;
    min_limit_next    = min_limit;
    max_limit_next    = max_limit;
    homed_next        = homed;
    phase1_next       = phase1;
    far_side_next     = far_side;
    stop_req_next     = stop_req;
    moving_next       = moving;
    timer_on_next     = timer_on;
    loaded_next       = 1'b0;
    cur_period_next   = cur_period;
    home_db_next      = home_db;
    far_db_next       = far_db;

    unique case (cmd_q.kind)
      KIND_EVENT: begin
        // ramp period load
        priority case (op)
          OP_FIRST: begin
            prev_period_next = start_period;
            remainder_next   = '0;
            cur_period_next  = start_period;
            loaded_next      = 1'b1;
            timer_on_next    = 1'b1;
          end
          OP_ACCEL: begin
            prev_period_next = p;
            remainder_next   = ({1'b0, step_count} + 33'd1 != {1'b0, accel_end}) ? div_r : '0;
            cur_period_next  = p;
            loaded_next      = 1'b1;
            timer_on_next    = 1'b1;
          end
          OP_DECEL: begin
            prev_period_next = p;
            remainder_next   = ({1'b0, step_count} + 33'd1 != {1'b0, total_steps}) ?
                               div_r : '0;
            cur_period_next  = p;
            loaded_next      = 1'b1;
            timer_on_next    = 1'b1;
          end
          OP_CRUISE: begin
            prev_period_next = div_q[31:0];
            cur_period_next  = div_q[31:0];
            loaded_next      = 1'b1;
            timer_on_next    = 1'b1;
            if (mode == M_VEL) begin
              step_count_next = csat({1'b0, step_count} + 33'd1);
              remainder_next  = '0;
            end
          end
          default: ;
        endcase

        tg = toggle_f({pulse_next, step_count_next, position_next}, direction);

        unique case (mode)
          M_STOP: begin
            pulse_next    = 1'b0;
            moving_next   = 1'b0;
            timer_on_next = 1'b0;
          end
          M_HOME: begin
            pulse_next      = tg.pulse;
            step_count_next = tg.sc;
            position_next   = tg.pos;
            if (!phase1) begin
              // seek: wait for either switch to read pressed
              if (!hp && !fp) begin
                home_db_next = '0;
                far_db_next  = '0;
              end else begin
                hf = hp && (home_db >= DB_LIM);
                ff = fp && (far_db >= DB_LIM);
                if (hp && !hf) home_db_next = home_db + 1'b1;
                if (fp && !ff) far_db_next = far_db + 1'b1;
                if (hf) far_side_next = 1'b0;
                else if (ff) far_side_next = 1'b1;
                if (hf || ff) begin
                  phase1_next     = 1'b1;
                  direction_next  = !direction;
                  cur_period_next = homing_period;
                  loaded_next     = 1'b1;
                  timer_on_next   = 1'b1;
                  home_db_next    = '0;
                  far_db_next     = '0;
                end
              end
            end else begin
              // back-off: wait for the switch to read released
              if (!far_side && !hp) begin
                if (home_db >= DB_LIM) fire = 1'b1;
                else home_db_next = home_db + 1'b1;
              end else if (far_side && !fp) begin
                if (far_db >= DB_LIM) fire = 1'b1;
                else far_db_next = far_db + 1'b1;
              end else begin
                home_db_next = '0;
                far_db_next  = '0;
              end
              if (fire) begin
                position_next = '0;
                if (far_side) begin
                  max_limit_next = '0;
                  min_limit_next = 32'd0 - {1'b0, axis_steps};
                end else begin
                  min_limit_next = '0;
                  max_limit_next = {1'b0, axis_steps};
                end
                homed_next    = 1'b1;
                mode_next     = M_STOP;
                moving_next   = 1'b0;
                timer_on_next = 1'b0;
              end
            end
          end
          default: begin
            // position and velocity: run on or finish
            if ((mode == M_POS || stop_req) && !(step_count < total_steps)) begin
              if (pulse) pulse_next = 1'b0;
              mode_next     = M_STOP;
              moving_next   = 1'b0;
              timer_on_next = 1'b0;
            end else begin
              pulse_next      = tg.pulse;
              step_count_next = tg.sc;
              position_next   = tg.pos;
            end
          end
        endcase
      end
      KIND_POS: begin
        total_steps_next  = csat({9'd0, cmd_q.steps});
        accel_end_next    = csat({9'd0, acc_c});
        decel_start_next  = csat({9'd0, cmd_q.steps - dec_c});
        target_freq_next  = cmd_q.freq;
        direction_next    = cmd_q.dir;
        start_period_next = (acc_c != '0) ? cmd_q.first_period : div_q[31:0];
        mode_next         = M_POS;
        stop_req_next     = 1'b0;
        step_count_next   = '0;
        moving_next       = 1'b1;
        cur_period_next   = start_period_next;
        loaded_next       = 1'b1;
        timer_on_next     = 1'b1;
      end
      KIND_VEL: begin
        target_freq_next  = cmd_q.freq;
        accel_end_next    = csat({9'd0, cmd_q.accel_len});
        direction_next    = cmd_q.dir;
        start_period_next = (cmd_q.accel_len != '0) ? cmd_q.first_period : div_q[31:0];
        mode_next         = M_VEL;
        stop_req_next     = 1'b0;
        step_count_next   = '0;
        moving_next       = 1'b1;
        cur_period_next   = start_period_next;
        loaded_next       = 1'b1;
        timer_on_next     = 1'b1;
      end
      KIND_DECEL: begin
        if (mode == M_VEL || mode == M_POS) stop_req_next = 1'b1;
        if (mode == M_POS) decel_start_next = step_count;
        total_steps_next = csat({1'b0, step_count} + {9'd0, cmd_q.steps});
      end
      KIND_HOME: begin
        if (switches_present) begin
          direction_next   = cmd_q.dir;
          target_freq_next = cmd_q.freq;
          mode_next        = M_HOME;
          homed_next       = 1'b0;
          phase1_next      = 1'b0;
          far_side_next    = 1'b0;
          home_db_next     = '0;
          far_db_next      = '0;
          step_count_next  = '0;
          moving_next      = 1'b1;
          cur_period_next  = div_q[31:0];
          loaded_next      = 1'b1;
          timer_on_next    = 1'b1;
        end
      end
      KIND_HALT: begin
        if (pulse) pulse_next = 1'b0;
        mode_next     = M_STOP;
        moving_next   = 1'b0;
        timer_on_next = 1'b0;
      end
      default: ;
    endcase
  end

  // --------------------------------------------------------------------------
  // sequencer
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) state <= S_IDLE;
    else     state <= state_next;
  end

  always_comb begin
    state_next = state;
    cmd_ready  = 1'b0;
    unique case (state)
      S_IDLE: begin
        cmd_ready = 1'b1;
        if (cmd_valid) state_next = S_LIMIT;
      end
      S_LIMIT: state_next = S_PLAN;
      S_PLAN:  state_next = div_need ? S_DIV : S_APPLY;
      S_DIV:   if (div_done) state_next = S_APPLY;
      S_APPLY: state_next = S_HOLD;
      S_HOLD:  if (!res_valid || res_ready) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  // item capture
  always_ff @(posedge clk) begin
    if (cmd_valid && cmd_ready) cmd_q <= cmd;
  end

  // state update
  always_ff @(posedge clk) begin
    if (rst) begin
      mode         <= M_STOP;
      pulse        <= 1'b0;
      direction    <= 1'b0;
      step_count   <= '0;
      total_steps  <= '0;
      accel_end    <= '0;
      decel_start  <= '0;
      target_freq  <= 23'd1;
      start_period <= '0;
      prev_period  <= '0;
      remainder    <= '0;
      position     <= '0;
      min_limit    <= 32'h8000_0000;
      max_limit    <= 32'h7FFF_FFFF;
      homed        <= 1'b0;
      phase1       <= 1'b0;
      far_side     <= 1'b0;
      stop_req     <= 1'b0;
      moving       <= 1'b0;
      timer_on     <= 1'b0;
      loaded       <= 1'b0;
      cur_period   <= '0;
      home_db      <= '0;
      far_db       <= '0;
    end else if (state == S_LIMIT) begin
      // past a soft limit: decelerating stop over a fifth of a revolution
      if (limit_hit) begin
        if (mode == M_VEL || mode == M_POS) stop_req <= 1'b1;
        if (mode == M_POS) decel_start <= step_count;
        total_steps <= csat({1'b0, step_count} + {19'd0, spr_fifth});
      end
    end else if (state == S_APPLY) begin
      mode         <= mode_next;
      pulse        <= pulse_next;
      direction    <= direction_next;
      step_count   <= step_count_next;
      total_steps  <= total_steps_next;
      accel_end    <= accel_end_next;
      decel_start  <= decel_start_next;
      target_freq  <= target_freq_next;
      start_period <= start_period_next;
      prev_period  <= prev_period_next;
      remainder    <= remainder_next;
      position     <= position_next;
      min_limit    <= min_limit_next;
      max_limit    <= max_limit_next;
      homed        <= homed_next;
      phase1       <= phase1_next;
      far_side     <= far_side_next;
      stop_req     <= stop_req_next;
      moving       <= moving_next;
      timer_on     <= timer_on_next;
      loaded       <= loaded_next;
      cur_period   <= cur_period_next;
      home_db      <= home_db_next;
      far_db       <= far_db_next;
    end
  end

  // --------------------------------------------------------------------------
  // result register: one transaction per item
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (state == S_HOLD && (!res_valid || res_ready)) begin
      res_valid <= 1'b1;
    end else if (res_ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_HOLD && (!res_valid || res_ready)) begin
      res.pulse_level   <= pulse;
      res.dir_level     <= direction;
      res.period        <= cur_period;
      res.period_load   <= loaded;
      res.timer_on      <= timer_on;
      res.moving        <= moving;
      res.homed         <= homed;
      res.mode          <= mode;
      res.step_position <= $signed(position);
    end
  end

`ifndef SYNTHESIS
  a_count_sat: assert property (@(posedge clk) disable iff (rst) step_count <= CMAX)
    else $error("step count beyond saturation bound");
  a_div_wait: assert property (@(posedge clk) disable iff (rst)
      (state == S_DIV) |-> (div_busy || div_done))
    else $error("waiting on an idle divider");
  a_home_stop: assert property (@(posedge clk) disable iff (rst) $rose(homed) |-> mode == M_STOP)
    else $error("homed set while not stopped");
  a_timer_moving: assert property (@(posedge clk) disable iff (rst) !moving |-> !timer_on)
    else $error("timer running with no motion");
`endif

endmodule

`default_nettype wire

### hdl/stpg_div.sv
// ----------------------------------------------------------------------------
// stpg_div
// Signed serial divider, one quotient bit per cycle, C-style truncation.
// ----------------------------------------------------------------------------
`default_nettype none

module stpg_div (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           start,
  input  wire logic signed [stpg_pkg::DIV_W-1:0] num,
  input  wire logic signed [stpg_pkg::DIV_W-1:0] den,
  output logic                                busy,
  output logic                                done,
  output logic signed [stpg_pkg::DIV_W-1:0]   quot,
  output logic signed [stpg_pkg::DIV_W-1:0]   rem
);
  import stpg_pkg::*;

  localparam int CW = $clog2(DIV_W);

  logic [DIV_W:0]   acc;
  logic [DIV_W-1:0] quo;
  logic [DIV_W-1:0] dvs;
  logic [CW-1:0]    cnt;
  logic             q_neg;
  logic             r_neg;
  logic [DIV_W:0]   shifted;
  logic [DIV_W:0]   trial;

  assign shifted = {acc[DIV_W-1:0], quo[DIV_W-1]};
  assign trial   = shifted - {1'b0, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy  <= 1'b1;
        cnt   <= '0;
        acc   <= '0;
        quo   <= num[DIV_W-1] ? DIV_W'(-num) : num;
        dvs   <= den[DIV_W-1] ? DIV_W'(-den) : den;
        q_neg <= num[DIV_W-1] ^ den[DIV_W-1];
        r_neg <= num[DIV_W-1];
      end else if (busy) begin
        if (!trial[DIV_W]) begin
          acc <= trial;
          quo <= {quo[DIV_W-2:0], 1'b1};
        end else begin
          acc <= shifted;
          quo <= {quo[DIV_W-2:0], 1'b0};
        end
        cnt <= cnt + 1'b1;
        if (cnt == CW'(DIV_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign quot = q_neg ? DIV_W'(-quo) : quo;
  assign rem  = r_neg ? DIV_W'(-acc[DIV_W-1:0]) : acc[DIV_W-1:0];

`ifndef SYNTHESIS
  a_no_restart: assert property (@(posedge clk) disable iff (rst) busy |-> !start)
    else $error("divider restarted while busy");
  a_done_once: assert property (@(posedge clk) disable iff (rst) done |=> !done)
    else $error("divider done held for more than one cycle");
  a_done_idle: assert property (@(posedge clk) disable iff (rst) done |-> !busy)
    else $error("divider done while still busy");
`endif

endmodule

`default_nettype wire

### tb/sv/tb_stepper_trapezoid_pulse_generator_core.sv
// ----------------------------------------------------------------------------
// tb_stepper_trapezoid_pulse_generator_core
// Self-checking bench for the stepper ramp pulse generator: moves, velocity
// runs, decelerating stops, homing and soft-limit stops, checked against an
// in-bench ramp predictor, with random idling and back-pressure on both sides.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_stepper_trapezoid_pulse_generator_core;
  import stpg_pkg::*;

  localparam int DEBOUNCE = 10;
  localparam logic [31:0] CNT_MAX = 32'hFFFF_FFFF;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cmd_valid = 1'b0;
  logic cmd_ready;
  cmd_t cmd = '0;
  logic res_valid;
  logic res_ready = 1'b0;
  res_t res;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [2:0] cfg_index = CFG_HALF_CLOCK;
  logic [31:0] cfg_data = '0;

  always #6 clk = ~clk;

  stepper_trapezoid_pulse_generator_core u_dut (
    .clk(clk), .rst(rst),
    .cmd_valid(cmd_valid), .cmd_ready(cmd_ready), .cmd(cmd),
    .res_valid(res_valid), .res_ready(res_ready), .res(res),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  // pending commands / events and expected status transactions
  cmd_t cmd_q[$];
  res_t status_q[$];
  int errors = 0;
  int n_items = 0;
  logic quiet = 1'b0;      // no idling while set
  int hold_cnt = 0;        // receiver hold-off, in cycles

  // --------------------------------------------------------------------------
  // Ramp predictor state
  // --------------------------------------------------------------------------
  logic [25:0] half_clk;
  logic [15:0] spr;
  logic [30:0] axis_len;
  logic [31:0] home_per;
  logic        sw_en;

  mode_t       p_mode;
  logic        p_pulse, p_dir;
  logic [31:0] p_cnt, p_total, p_acc_end, p_dec_start, p_start_per, p_prev_per;
  logic [31:0] p_pos, p_min, p_max, p_period;
  logic [22:0] p_freq;
  longint      p_rem;
  int          p_hdb, p_fdb;
  logic        p_homed, p_backoff, p_far_side, p_stop_req, p_moving, p_timer, p_loaded;

  task automatic model_reset();
    half_clk = 26'd5250000; spr = 16'd200; axis_len = '0; home_per = 32'd52500;
    sw_en = 1'b0;
    p_mode = M_STOP; p_pulse = 1'b0; p_dir = 1'b0;
    p_cnt = 0; p_total = 0; p_acc_end = 0; p_dec_start = 0;
    p_freq = 23'd1; p_start_per = 0; p_prev_per = 0; p_rem = '0;
    p_pos = 0; p_min = 32'h8000_0000; p_max = 32'h7FFF_FFFF;
    p_hdb = 0; p_fdb = 0; p_period = 0;
    p_homed = 1'b0; p_backoff = 1'b0; p_far_side = 1'b0; p_stop_req = 1'b0;
    p_moving = 1'b0; p_timer = 1'b0; p_loaded = 1'b0;
  endtask

  function automatic logic [31:0] sat_cnt(longint unsigned v);
    return (v > longint'(CNT_MAX)) ? CNT_MAX : v[31:0];
  endfunction

  function automatic logic [31:0] period_for(logic [22:0] f);
    return 32'(half_clk / ((f == 0) ? 26'd1 : 26'(f)));
  endfunction

  function automatic void load_period(logic [31:0] p);
    p_period = p; p_loaded = 1'b1; p_timer = 1'b1;
  endfunction

  function automatic void step_toggle();
    if (p_pulse) begin
      p_pulse = 1'b0;
    end else begin
      p_pulse = 1'b1;
      if (p_cnt < CNT_MAX) p_cnt++;
      p_pos = p_pos + (p_dir ? 32'd1 : 32'hFFFF_FFFF);
    end
  endfunction

  function automatic void halt_motion();
    if (p_pulse) step_toggle();
    p_mode = M_STOP; p_moving = 1'b0; p_timer = 1'b0;
  endfunction

  function automatic void begin_decel(logic [31:0] n);
    if (p_mode == M_VEL || p_mode == M_POS) p_stop_req = 1'b1;
    if (p_mode == M_POS) p_dec_start = p_cnt;
    p_total = sat_cnt(longint'(p_cnt) + longint'(n));
  endfunction

  // c' = c - (2c + r) / (4n + 1), remainder carried except on the last step
  function automatic void ramp_next(logic decel);
    longint num, den, q;
    logic [31:0] bound;
    num = 2 * longint'(p_prev_per) + p_rem;
    den = decel ? 4 * (longint'(p_cnt) - longint'(p_total)) + 1 : 4 * longint'(p_cnt) + 1;
    bound = decel ? p_total : p_acc_end;
    q = num / den;
    p_rem = (longint'(p_cnt) + 1 != longint'(bound)) ? num % den : 0;
    p_prev_per = p_prev_per - q[31:0];
    load_period(p_prev_per);
  endfunction

  function automatic void first_step();
    p_prev_per = p_start_per; p_rem = '0; load_period(p_start_per);
  endfunction

  function automatic void cruise_step();
    p_prev_per = period_for(p_freq); load_period(p_prev_per);
  endfunction

  function automatic void start_motion(logic [31:0] p);
    p_cnt = 0; p_moving = 1'b1; load_period(p);
  endfunction

  function automatic void homing_event(logic home_pr, logic far_pr);
    logic hf, ff, fire;
    step_toggle();
    if (!p_backoff) begin
      if (!home_pr && !far_pr) begin
        p_hdb = 0; p_fdb = 0;
        return;
      end
      hf = home_pr && p_hdb >= DEBOUNCE;
      ff = far_pr && p_fdb >= DEBOUNCE;
      if (home_pr && !hf) p_hdb++;
      if (far_pr && !ff) p_fdb++;
      if (hf) p_far_side = 1'b0;
      else if (ff) p_far_side = 1'b1;
      if (hf || ff) begin
        p_backoff = 1'b1; p_dir = ~p_dir; load_period(home_per);
        p_hdb = 0; p_fdb = 0;
      end
    end else begin
      fire = 1'b0;
      if (!p_far_side && !home_pr) begin
        if (p_hdb >= DEBOUNCE) fire = 1'b1; else p_hdb++;
      end else if (p_far_side && !far_pr) begin
        if (p_fdb >= DEBOUNCE) fire = 1'b1; else p_fdb++;
      end else begin
        p_hdb = 0; p_fdb = 0;
      end
      if (fire) begin
        p_pos = 0;
        if (p_far_side) begin
          p_max = 0; p_min = 32'd0 - 32'(axis_len);
        end else begin
          p_min = 0; p_max = 32'(axis_len);
        end
        p_homed = 1'b1; p_mode = M_STOP; p_moving = 1'b0; p_timer = 1'b0;
      end
    end
  endfunction

  function automatic void timer_event(logic home_pr, logic far_pr);
    if (p_homed && !p_stop_req) begin
      if ((p_dir && $signed(p_pos) > $signed(p_max)) ||
          (!p_dir && $signed(p_pos) < $signed(p_min)))
        begin_decel(32'(spr / 16'd5));
    end
    case (p_mode)
      M_STOP: halt_motion();
      M_HOME: homing_event(home_pr, far_pr);
      M_POS: begin
        if (p_cnt < p_total) begin
          if (!p_pulse) begin
            if (p_cnt == 0) first_step();
            else if (p_cnt < p_acc_end) ramp_next(1'b0);
            else if (p_cnt < p_dec_start &&
                     longint'(p_dec_start) != longint'(p_acc_end) + 1) cruise_step();
            else ramp_next(1'b1);
          end
          step_toggle();
        end else begin
          halt_motion();
        end
      end
      default: begin
        if (p_stop_req) begin
          if (p_cnt < p_total) begin
            if (!p_pulse) ramp_next(1'b1);
            step_toggle();
          end else begin
            halt_motion();
          end
        end else begin
          if (!p_pulse) begin
            if (p_cnt == 0) first_step();
            else if (p_cnt < p_acc_end) ramp_next(1'b0);
            else if (p_cnt == p_acc_end) begin
              cruise_step();
              p_cnt = sat_cnt(longint'(p_cnt) + 1);
              p_rem = '0;
            end
          end
          step_toggle();
        end
      end
    endcase
  endfunction

  function automatic res_t predict_status(cmd_t c);
    logic [31:0] acc, dec, stp;
    res_t r;
    acc = 32'(c.accel_len); dec = 32'(c.decel_len); stp = 32'(c.steps);
    p_loaded = 1'b0;
    case (c.kind)
      KIND_EVENT: timer_event(!c.home_switch, !c.far_switch);
      KIND_POS: begin
        if (acc > stp) acc = stp;
        if (dec > stp) dec = stp;
        if (acc + dec > stp) begin
          acc = stp / 2; dec = stp / 2;
        end
        p_total = stp; p_acc_end = acc; p_dec_start = stp - dec;
        p_freq = c.freq; p_dir = c.dir;
        p_start_per = (acc != 0) ? c.first_period : period_for(c.freq);
        p_mode = M_POS; p_stop_req = 1'b0;
        start_motion(p_start_per);
      end
      KIND_VEL: begin
        p_freq = c.freq; p_acc_end = acc; p_dir = c.dir;
        p_start_per = (acc != 0) ? c.first_period : period_for(c.freq);
        p_mode = M_VEL; p_stop_req = 1'b0;
        start_motion(p_start_per);
      end
      KIND_DECEL: begin_decel(stp);
      KIND_HOME: begin
        if (sw_en) begin
          p_dir = c.dir; p_freq = c.freq; p_mode = M_HOME;
          p_homed = 1'b0; p_backoff = 1'b0; p_far_side = 1'b0; p_hdb = 0; p_fdb = 0;
          start_motion(period_for(c.freq));
        end
      end
      KIND_HALT: halt_motion();
      default: ;
    endcase
    r.pulse_level = p_pulse; r.dir_level = p_dir; r.period = p_period;
    r.period_load = p_loaded; r.timer_on = p_timer; r.moving = p_moving;
    r.homed = p_homed; r.mode = p_mode; r.step_position = p_pos;
    return r;
  endfunction

  // --------------------------------------------------------------------------
  // Driver: command transactions fed from cmd_q; expectation formed on accept
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst) begin
      cmd_valid <= 1'b0;
    end else begin
      if (cmd_valid && cmd_ready) status_q.push_back(predict_status(cmd));
      if (!cmd_valid || cmd_ready) begin
        if (cmd_q.size() != 0 && (quiet || $urandom_range(99) >= 10)) begin
          cmd <= cmd_q.pop_front();
          cmd_valid <= 1'b1;
        end else begin
          cmd_valid <= 1'b0;
        end
      end
    end
  end

  // hold-off counter, own process
  always @(posedge clk) begin
    if (hold_cnt != 0) hold_cnt <= hold_cnt - 1;
  end

  task automatic report_mismatch(string field, logic [31:0] got, logic [31:0] want);
    $display("mismatch %s: got %h, want %h (t=%0t)", field, got, want, $time);
    errors++;
  endtask

  // Monitor: each status transaction against the oldest expectation
  always @(posedge clk) begin
    res_t w;
    if (rst) begin
      res_ready <= 1'b0;
    end else begin
      if (res_valid && res_ready) begin
        if (status_q.size() == 0) begin
          report_mismatch("unexpected transaction", 32'(res.mode), 32'hX);
        end else begin
          w = status_q.pop_front();
          if (res.pulse_level !== w.pulse_level)
            report_mismatch("pulse_level", 32'(res.pulse_level), 32'(w.pulse_level));
          if (res.dir_level !== w.dir_level)
            report_mismatch("dir_level", 32'(res.dir_level), 32'(w.dir_level));
          if (res.period !== w.period) report_mismatch("period", res.period, w.period);
          if (res.period_load !== w.period_load)
            report_mismatch("period_load", 32'(res.period_load), 32'(w.period_load));
          if (res.timer_on !== w.timer_on)
            report_mismatch("timer_on", 32'(res.timer_on), 32'(w.timer_on));
          if (res.moving !== w.moving)
            report_mismatch("moving", 32'(res.moving), 32'(w.moving));
          if (res.homed !== w.homed) report_mismatch("homed", 32'(res.homed), 32'(w.homed));
          if (res.mode !== w.mode) report_mismatch("mode", 32'(res.mode), 32'(w.mode));
          if (res.step_position !== w.step_position)
            report_mismatch("step_position", res.step_position, w.step_position);
        end
      end
      res_ready <= (hold_cnt == 0) && (quiet || $urandom_range(99) >= 10);
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus helpers
  // --------------------------------------------------------------------------
  function automatic cmd_t rand_cmd(logic [2:0] k);
    cmd_t c;
    logic [159:0] raw;
    raw = {$urandom, $urandom, $urandom, $urandom, $urandom};
    c = raw[$bits(cmd_t)-1:0];
    c.kind = k;
    return c;
  endfunction

  task automatic push_item(cmd_t c);
    cmd_q.push_back(c);
    n_items++;
  endtask

  function automatic logic [22:0] rand_freq();
    case ($urandom_range(9))
      0: return 23'd0;
      1: return 23'($urandom);
      default: return 23'($urandom_range(5250000, 1));
    endcase
  endfunction

  task automatic push_event(logic hsw, logic fsw);
    cmd_t c;
    c = rand_cmd(KIND_EVENT);
    c.home_switch = hsw; c.far_switch = fsw;
    push_item(c);
  endtask

  task automatic push_events(int n);
    repeat (n) push_event(1'($urandom), 1'($urandom));
  endtask

  task automatic push_move(logic [2:0] k, int len, int acc, int dec, logic d);
    cmd_t c;
    c = rand_cmd(k);
    c.steps = 24'(len); c.accel_len = 24'(acc); c.decel_len = 24'(dec);
    c.freq = rand_freq(); c.dir = d;
    push_item(c);
  endtask

  // homing: approach until a switch debounces, back off until released
  task automatic push_homing(logic use_far);
    cmd_t c;
    logic s;
    c = rand_cmd(KIND_HOME);
    c.freq = rand_freq();
    push_item(c);
    repeat ($urandom_range(4)) push_event(1'b1, 1'b1);
    if ($urandom_range(3) == 0) begin
      // broken press, counter restarts
      repeat ($urandom_range(6, 1)) push_event(use_far, !use_far);
      push_event(1'b1, 1'b1);
    end
    s = ($urandom_range(7) == 0);  // both pressed now and then
    repeat (DEBOUNCE + 1 + $urandom_range(1))
      push_event(use_far & ~s, ~use_far & ~s);
    repeat ($urandom_range(4)) push_event(use_far, !use_far);
    if ($urandom_range(3) == 0) begin
      repeat ($urandom_range(5, 1)) push_event(1'b1, 1'b1);
      push_event(use_far, !use_far);
    end
    repeat (DEBOUNCE + 1 + $urandom_range(2)) push_event(1'b1, 1'b1);
  endtask

  task automatic push_sequence();
    int r, len, acc;
    r = $urandom_range(99);
    if (r < 30) begin
      len = ($urandom_range(19) == 0) ? $urandom_range(16777215) : $urandom_range(40);
      push_move(KIND_POS, len, $urandom_range(len + 5), $urandom_range(len + 5),
                1'($urandom));
      if (len > 40) begin
        push_events($urandom_range(30, 5));
        push_item(rand_cmd(KIND_HALT));
      end else begin
        push_events(2 * len + 3);
      end
    end else if (r < 50) begin
      acc = $urandom_range(20);
      push_move(KIND_VEL, 0, acc, 0, 1'($urandom));
      push_events(2 * acc + $urandom_range(20));
      if ($urandom_range(4) == 0) begin
        push_item(rand_cmd(KIND_HALT));
        push_events($urandom_range(2));
      end else begin
        len = $urandom_range(15);
        push_move(KIND_DECEL, len, 0, 0, 1'($urandom));
        push_events(2 * len + 4);
      end
    end else if (r < 70 && sw_en) begin
      push_homing(1'($urandom));
    end else if (r < 90) begin
      // long move, may cross a soft limit once homed
      len = $urandom_range(60, 10);
      push_move(KIND_POS, len, $urandom_range(10), $urandom_range(10), 1'($urandom));
      push_events(2 * len + 4);
    end else begin
      repeat (5) push_item(rand_cmd(3'($urandom)));
      push_item(rand_cmd(KIND_HALT));
      push_events(2);
    end
  endtask

  task automatic cfg_write(logic [2:0] idx, logic [31:0] d);
    @(posedge clk);
    cfg_valid <= 1'b1; cfg_index <= idx; cfg_data <= d;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      CFG_HALF_CLOCK: half_clk = d[25:0];
      CFG_SPR:        spr = d[15:0];
      CFG_AXIS:       axis_len = d[30:0];
      CFG_HOME_PER:   home_per = d;
      CFG_SWITCHES:   sw_en = d[0];
      default: ;
    endcase
    cfg_valid <= 1'b0;
  endtask

  // idle means every expectation met and the block given time to settle
  task automatic wait_drained();
    while (cmd_q.size() != 0 || status_q.size() != 0 || cmd_valid) @(posedge clk);
    repeat (60) @(posedge clk);
  endtask

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin
    int ph;
    model_reset();
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // directed: extremes, every command, the odd corners
    push_event(1'b1, 1'b1);                           // event while stopped
    push_move(KIND_POS, 3, 0, 0, 1'b1);               // no accel, period from freq
    push_events(8);
    push_move(KIND_POS, 6, 5, 5, 1'b0);               // acc + dec over length
    push_events(16);
    push_move(KIND_POS, 16777215, 16777215, 16777215, 1'b1);
    push_events(4);
    push_move(KIND_DECEL, 16777215, 0, 0, 1'b0);      // longest decelerating stop
    push_events(3);
    push_move(KIND_VEL, 0, 2, 0, 1'b1);
    push_events(9);
    push_move(KIND_DECEL, 2, 0, 0, 1'b0);
    push_events(7);
    push_item(rand_cmd(KIND_HOME));                   // ignored, no switches
    push_item(rand_cmd(3'd6));
    push_item(rand_cmd(3'd7));
    push_item(rand_cmd(KIND_HALT));
    wait_drained();

    ph = 0;
    while (n_items < 1550) begin
      ph++;
      case (ph)
        1: begin
          cfg_write(CFG_HALF_CLOCK, 32'd1); cfg_write(CFG_SPR, 32'd1);
          cfg_write(CFG_AXIS, 32'd0); cfg_write(CFG_HOME_PER, 32'd1);
          cfg_write(CFG_SWITCHES, 32'd1);
        end
        2: begin
          cfg_write(CFG_HALF_CLOCK, 32'd42000000); cfg_write(CFG_SPR, 32'd51200);
          cfg_write(CFG_AXIS, 32'h7FFF_FFFF); cfg_write(CFG_HOME_PER, 32'hFFFF_FFFF);
          cfg_write(CFG_SWITCHES, 32'd1);
        end
        default: begin
          cfg_write(CFG_HALF_CLOCK, $urandom_range(42000000, 1));
          cfg_write(CFG_SPR, ($urandom_range(1)) ? $urandom_range(60, 1)
                                                 : $urandom_range(51200, 1));
          cfg_write(CFG_AXIS, ($urandom_range(4) == 0) ? ($urandom & 32'h7FFF_FFFF)
                                                       : $urandom_range(40));
          cfg_write(CFG_HOME_PER, ($urandom == 0) ? 32'd1 : $urandom);
          cfg_write(CFG_SWITCHES, 32'($urandom_range(3) != 0));
        end
      endcase
      quiet <= (ph == 3);
      while (cmd_q.size() < 160) push_sequence();
      if (ph == 4) begin
        // long receiver stall while commands keep coming
        @(posedge clk);
        hold_cnt <= 400;
      end
      wait_drained();
    end

    if (errors == 0) begin
      $display("[stepper_trapezoid_pulse_generator_core] OK");
    end else begin
      $display("[stepper_trapezoid_pulse_generator_core] ERROR");
    end
    $finish;
  end

  initial begin
    #40ms;
    $display("[stepper_trapezoid_pulse_generator_core] ERROR");
    $finish;
  end

endmodule
